[rtl/tch_pkg.sv]
package tch_pkg;

  // Input sample width and derived packing
  localparam int SAMPLE_W     = 16;
  localparam int IN_TDATA_W   = 6 * SAMPLE_W;

  // Pipeline depths of the iterative units
  localparam int SQRT_STAGES  = 16;
  localparam int DIV_STAGES   = 16;
  localparam int CORDIC_STEPS = 16;

  // Datapath widths
  localparam int XY_W  = 36;   // tilted magnetic X/Y
  localparam int CW    = 40;   // CORDIC X/Y with gain headroom
  localparam int ZW    = 28;   // angle in 2^-16 degree

  // Angle constants
  localparam logic [14:0] FULL_TURN       = 15'd23040;
  localparam logic [14:0] DECL_RESET      = 15'd704;
  localparam logic signed [ZW-1:0] ANG_180 = 28'sd11796480;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd2949120;
      1:  v = 28'sd1740967;
      2:  v = 28'sd919879;
      3:  v = 28'sd466945;
      4:  v = 28'sd234379;
      5:  v = 28'sd117304;
      6:  v = 28'sd58666;
      7:  v = 28'sd29335;
      8:  v = 28'sd14668;
      9:  v = 28'sd7334;
      10: v = 28'sd3667;
      11: v = 28'sd1833;
      12: v = 28'sd917;
      13: v = 28'sd458;
      14: v = 28'sd229;
      15: v = 28'sd115;
      16: v = 28'sd57;
      17: v = 28'sd29;
      18: v = 28'sd14;
      19: v = 28'sd7;
      20: v = 28'sd4;
      21: v = 28'sd2;
      22: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tch_isqrt.sv]
module tch_isqrt import tch_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);

  logic [17:0] rem_r  [SQRT_STAGES];
  logic [15:0] root_r [SQRT_STAGES];
  logic [31:0] rad_r  [SQRT_STAGES];

  // One root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [17:0] rem_in;
    logic [15:0] root_in;
    logic [31:0] rad_in;
    logic [17:0] rem_sh;
    logic [17:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign rem_sh = {rem_in[15:0], rad_in[31:30]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[14:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[14:0], 1'b0};
        end
        rad_r[k] <= {rad_in[29:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[SQRT_STAGES-1];

endmodule

[rtl/tch_div.sv]
module tch_div import tch_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] rem_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic [15:0] quo_o
);

  logic [15:0] rem_r [DIV_STAGES];
  logic [15:0] num_r [DIV_STAGES];
  logic [15:0] den_r [DIV_STAGES];
  logic [15:0] quo_r [DIV_STAGES];

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [15:0] rem_in;
    logic [15:0] num_in;
    logic [15:0] den_in;
    logic [15:0] quo_in;
    logic [16:0] trial;
    logic [16:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, num_in[15]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_in}) begin
          rem_r[k] <= diff[15:0];
          quo_r[k] <= {quo_in[14:0], 1'b1};
        end else begin
          rem_r[k] <= trial[15:0];
          quo_r[k] <= {quo_in[14:0], 1'b0};
        end
        num_r[k] <= {num_in[14:0], 1'b0};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

[rtl/tch_cordic.sv]
module tch_cordic import tch_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];

  // Vectoring steps: rotate toward Y = 0 and accumulate the angle
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (k == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_in[CW-1]) begin
          x_r[k] <= x_in + dx;
          y_r[k] <= y_in - dy;
          z_r[k] <= z_in + atan_entry(k);
        end else begin
          x_r[k] <= x_in - dx;
          y_r[k] <= y_in + dy;
          z_r[k] <= z_in - atan_entry(k);
        end
      end
    end
  end

  assign z_o = z_r[CORDIC_STEPS-1];

endmodule

[rtl/tilt_compensated_heading_unit.sv]
// Tilt-compensated compass heading.
// in_*  : one item per sensor sample pair; in_tdata packs acc_x, acc_y, acc_z,
//         mag_x, mag_y, mag_z (16 bit signed each, acc_x lowest).
// out_* : one item per input item, in order; out_tdata[14:0] is the heading
//         in 1/64 degree (0..23039), out_tuser[0] flags a defined heading.
// cfg_* : declination in 1/64 degree, added before the wrap to 360 degrees;
//         write it only while no item is in flight.
// The pipeline has two stages for the squared norm, a 16-stage square
// root, a 16-stage divider for the roll and pitch sines, two stages for sign,
// clamp and cosine argument, a 16-stage square root for the cosines, four
// stages of products and sums for the tilted vector, one fold stage, a
// 16-stage CORDIC and two stages for the declination and wrap.
// Throughput is one item per cycle unless stalled; every stage is a register.
// Reset empties the pipeline and sets the declination to 11 degrees.
// When the receiver stalls, the whole pipeline holds: in_tready follows the
// output register, and nothing is lost or repeated.
module tilt_compensated_heading_unit import tch_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // heading[14:0], zero pad
  output logic [0:0]            out_tuser,  // valid_res
  input  logic                  cfg_wr_en,
  input  logic [14:0]           cfg_wr_data
);

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  typedef struct packed {
    smp_t ax;
    smp_t ay;
    smp_t mx;
    smp_t my;
    smp_t mz;
  } side_a_t;

  typedef struct packed {
    logic sx;
    logic sy;
    logic nz;
    smp_t mx;
    smp_t my;
    smp_t mz;
  } side_b_t;

  typedef struct packed {
    smp_t sr;
    smp_t sp;
    logic nz;
    smp_t mx;
    smp_t my;
    smp_t mz;
  } side_c_t;

  logic en;
  logic [14:0] decl_r;

  // Declination register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= DECL_RESET;
    end else if (cfg_wr_en) begin
      decl_r <= cfg_wr_data;
    end
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 1: capture and square the acceleration
  smp_t in_ax, in_ay, in_az;
  assign in_ax = in_tdata[SAMPLE_W-1:0];
  assign in_ay = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_az = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

  logic        s1_v_r;
  side_a_t     s1_side_r;
  logic [30:0] sqx_r, sqy_r, sqz_r;
  logic signed [31:0] sqx_nxt, sqy_nxt, sqz_nxt;

  assign sqx_nxt = in_ax * in_ax;
  assign sqy_nxt = in_ay * in_ay;
  assign sqz_nxt = in_az * in_az;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= sqx_nxt[30:0];
      sqy_r     <= sqy_nxt[30:0];
      sqz_r     <= sqz_nxt[30:0];
      s1_side_r <= '{ax: in_ax, ay: in_ay,
                     mx: in_tdata[4*SAMPLE_W-1:3*SAMPLE_W],
                     my: in_tdata[5*SAMPLE_W-1:4*SAMPLE_W],
                     mz: in_tdata[6*SAMPLE_W-1:5*SAMPLE_W]};
    end
  end

  // Stage 2: squared norm
  logic        s2_v_r;
  side_a_t     s2_side_r;
  logic [31:0] n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r      <= {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};
      s2_side_r <= s1_side_r;
    end
  end

  // Norm square root, side data delayed alongside
  logic [15:0] norm;
  tch_isqrt u_norm (.clk(clk), .en(en), .rad_i(n2_r), .root_o(norm));

  side_a_t da_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= '0;
    else if (en) va_r <= {va_r[SQRT_STAGES-2:0], s2_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0] <= s2_side_r;
      for (int k = 1; k < SQRT_STAGES; k++) da_r[k] <= da_r[k-1];
    end
  end

  // Divide |ay| and |ax| (scaled by 2^15) by the norm
  side_a_t sa;
  logic [15:0] abs_x, abs_y;
  assign sa    = da_r[SQRT_STAGES-1];
  assign abs_x = sa.ax[SAMPLE_W-1] ? 16'(-sa.ax) : 16'(sa.ax);
  assign abs_y = sa.ay[SAMPLE_W-1] ? 16'(-sa.ay) : 16'(sa.ay);

  logic [15:0] quo_x, quo_y;
  tch_div u_div_y (.clk(clk), .en(en), .rem_i({1'b0, abs_y[15:1]}),
                   .num_i({abs_y[0], 15'd0}), .den_i(norm), .quo_o(quo_y));
  tch_div u_div_x (.clk(clk), .en(en), .rem_i({1'b0, abs_x[15:1]}),
                   .num_i({abs_x[0], 15'd0}), .den_i(norm), .quo_o(quo_x));

  side_b_t db_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= '0;
    else if (en) vb_r <= {vb_r[DIV_STAGES-2:0], va_r[SQRT_STAGES-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db_r[0] <= '{sx: sa.ax[SAMPLE_W-1], sy: sa.ay[SAMPLE_W-1], nz: (norm != 16'd0),
                   mx: sa.mx, my: sa.my, mz: sa.mz};
      for (int k = 1; k < DIV_STAGES; k++) db_r[k] <= db_r[k-1];
    end
  end

  // Stage 4: sign and clamp to Q1.15
  side_b_t sb;
  logic [15:0] mag_x, mag_y;
  assign sb    = db_r[DIV_STAGES-1];
  assign mag_x = quo_x[15] ? 16'h7FFF : quo_x;
  assign mag_y = quo_y[15] ? 16'h7FFF : quo_y;

  logic    s4_v_r;
  side_c_t s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= vb_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= '{sr: sb.sy ? $signed(~mag_y + 16'd1) : $signed(mag_y),
                sp: sb.sx ? $signed(~mag_x + 16'd1) : $signed(mag_x),
                nz: sb.nz, mx: sb.mx, my: sb.my, mz: sb.mz};
    end
  end

  // Stage 5: cosine arguments 2^30 - s^2
  logic signed [31:0] ssr_nxt, ssp_nxt;
  assign ssr_nxt = s4_r.sr * s4_r.sr;
  assign ssp_nxt = s4_r.sp * s4_r.sp;

  logic        s5_v_r;
  side_c_t     s5_r;
  logic [31:0] argr_r, argp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      argr_r <= 32'h4000_0000 - ssr_nxt;
      argp_r <= 32'h4000_0000 - ssp_nxt;
      s5_r   <= s4_r;
    end
  end

  logic [15:0] cr, cp;
  tch_isqrt u_cos_r (.clk(clk), .en(en), .rad_i(argr_r), .root_o(cr));
  tch_isqrt u_cos_p (.clk(clk), .en(en), .rad_i(argp_r), .root_o(cp));

  side_c_t dc_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= '0;
    else if (en) vc_r <= {vc_r[SQRT_STAGES-2:0], s5_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= s5_r;
      for (int k = 1; k < SQRT_STAGES; k++) dc_r[k] <= dc_r[k-1];
    end
  end

  // Stage 6: first products
  side_c_t sc;
  logic signed [16:0] cr_s, cp_s;
  assign sc   = dc_r[SQRT_STAGES-1];
  assign cr_s = {1'b0, cr};
  assign cp_s = {1'b0, cp};

  logic               s6_v_r, s6_nz_r;
  smp_t               s6_mx_r, s6_mz_r;
  logic signed [30:0] srsp_p_r, mzsp_r;
  logic signed [32:0] srcp_p_r, mxcp_r, mycr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= vc_r[SQRT_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srsp_p_r <= sc.sr * sc.sp;
      srcp_p_r <= sc.sr * cp_s;
      mxcp_r   <= sc.mx * cp_s;
      mzsp_r   <= sc.mz * sc.sp;
      mycr_r   <= sc.my * cr_s;
      s6_mx_r  <= sc.mx;
      s6_mz_r  <= sc.mz;
      s6_nz_r  <= sc.nz;
    end
  end

  // Stage 7: tilted X, scaled cross terms
  logic signed [30:0] srsp_sh;
  logic signed [32:0] srcp_sh;
  assign srsp_sh = srsp_p_r >>> 15;
  assign srcp_sh = srcp_p_r >>> 15;

  logic                 s7_v_r, s7_nz_r;
  smp_t                 s7_mx_r, s7_mz_r;
  logic signed [XY_W-1:0] s7_x_r;
  logic signed [15:0]   srsp_r;
  logic signed [17:0]   srcp_r;
  logic signed [32:0]   s7_mycr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (en) s7_v_r <= s6_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_x_r    <= XY_W'(mxcp_r) + XY_W'(mzsp_r);
      srsp_r    <= srsp_sh[15:0];
      srcp_r    <= srcp_sh[17:0];
      s7_mycr_r <= mycr_r;
      s7_mx_r   <= s6_mx_r;
      s7_mz_r   <= s6_mz_r;
      s7_nz_r   <= s6_nz_r;
    end
  end

  // Stage 8: remaining Y products
  logic                   s8_v_r, s8_nz_r;
  logic signed [XY_W-1:0] s8_x_r;
  logic signed [31:0]     mxsrsp_r;
  logic signed [33:0]     mzsrcp_r;
  logic signed [32:0]     s8_mycr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (en) s8_v_r <= s7_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxsrsp_r  <= s7_mx_r * srsp_r;
      mzsrcp_r  <= s7_mz_r * srcp_r;
      s8_mycr_r <= s7_mycr_r;
      s8_x_r    <= s7_x_r;
      s8_nz_r   <= s7_nz_r;
    end
  end

  // Stage 9: tilted Y
  logic                   s9_v_r, s9_nz_r;
  logic signed [XY_W-1:0] s9_x_r, s9_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else if (en) s9_v_r <= s8_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_y_r  <= XY_W'(mxsrsp_r) + XY_W'(s8_mycr_r) - XY_W'(mzsrcp_r);
      s9_x_r  <= s8_x_r;
      s9_nz_r <= s8_nz_r;
    end
  end

  // Stage 10: fold the left half plane onto the right, start angle
  logic                 s10_v_r, s10_ok_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s10_v_r <= 1'b0;
    else if (en) s10_v_r <= s9_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_ok_r <= s9_nz_r && !(s9_x_r == '0 && s9_y_r == '0);
      if (s9_x_r[XY_W-1]) begin
        cx_r <= -CW'(s9_x_r);
        cy_r <= -CW'(s9_y_r);
        cz_r <= s9_y_r[XY_W-1] ? -ANG_180 : ANG_180;
      end else begin
        cx_r <= CW'(s9_x_r);
        cy_r <= CW'(s9_y_r);
        cz_r <= '0;
      end
    end
  end

  logic signed [ZW-1:0] ang;
  tch_cordic u_cordic (.clk(clk), .en(en), .x_i(cx_r), .y_i(cy_r), .z_i(cz_r),
                       .z_o(ang));

  logic [CORDIC_STEPS-1:0] vd_r, okd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else if (en) vd_r <= {vd_r[CORDIC_STEPS-2:0], s10_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) okd_r <= {okd_r[CORDIC_STEPS-2:0], s10_ok_r};
  end

  // Stage 11: round to 1/64 degree, add declination, lift negatives
  logic signed [ZW-1:0]    ang_rnd;
  logic signed [ZW-11:0]   ang_q;
  logic signed [ZW-10:0]   sum_nxt;
  logic signed [ZW-10:0]   lift_nxt;
  assign ang_rnd  = ang + ZW'(512);
  assign ang_q    = ang_rnd[ZW-1:10];
  assign sum_nxt  = (ZW-9)'(ang_q) + $signed({4'd0, decl_r});
  assign lift_nxt = sum_nxt[ZW-10] ? sum_nxt + $signed({4'd0, FULL_TURN}) : sum_nxt;

  logic        s11_v_r, s11_ok_r;
  logic [15:0] s11_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s11_v_r <= 1'b0;
    else if (en) s11_v_r <= vd_r[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_h_r  <= lift_nxt[15:0];
      s11_ok_r <= okd_r[CORDIC_STEPS-1];
    end
  end

  // Output register: wrap into one turn
  logic [15:0] wrap_nxt;
  always_comb begin
    if (s11_h_r >= {FULL_TURN, 1'b0}) begin
      wrap_nxt = s11_h_r - {FULL_TURN, 1'b0};
    end else if (s11_h_r >= {1'b0, FULL_TURN}) begin
      wrap_nxt = s11_h_r - {1'b0, FULL_TURN};
    end else begin
      wrap_nxt = s11_h_r;
    end
  end

  logic [14:0] heading_r;
  logic        valid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s11_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading_r   <= s11_ok_r ? wrap_nxt[14:0] : 15'd0;
      valid_res_r <= s11_ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, heading_r};
  assign out_tuser  = valid_res_r;

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] < FULL_TURN)
    else $error("heading outside one turn");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tdata[14:0] == 15'd0)
    else $error("undefined heading not cleared");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tch_pkg::*;

  typedef struct packed {
    logic [14:0] heading;
    logic        valid_res;
  } heading_t;

  typedef struct {
    logic signed [15:0] ax, ay, az, mx, my, mz;
    bit                 typed;   // expected result given in the row
    heading_t           res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [14:0]           cfg_wr_data = '0;

  heading_t    heading_q[$];
  logic [14:0] decl_model = DECL_RESET;
  int          fail_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  tilt_compensated_heading_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sine_q15(input longint num, input longint den);
    longint q;
    q = (num * 32768) / den;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return q;
  endfunction

  // Tilt-compensate the magnetic vector and take its angle
  function automatic heading_t compute_heading(input logic signed [15:0] ax, ay, az,
                                               input logic signed [15:0] mx, my, mz);
    heading_t        r;
    longint          axl, ayl, azl, mxl, myl, mzl;
    longint unsigned n2;
    longint          n, sr, sp, cr, cp, srsp, srcp, x, y, z, dx, dy, h;
    axl = ax; ayl = ay; azl = az; mxl = mx; myl = my; mzl = mz;
    r = '0;
    n2 = axl * axl + ayl * ayl + azl * azl;
    n = int_sqrt(n2);
    if (n == 0) return r;
    sr = sine_q15(ayl, n);
    sp = sine_q15(axl, n);
    cr = int_sqrt(64'd1073741824 - sr * sr);
    cp = int_sqrt(64'd1073741824 - sp * sp);
    srsp = (sr * sp) >>> 15;
    srcp = (sr * cp) >>> 15;
    x = mxl * cp + mzl * sp;
    y = mxl * srsp + myl * cr - mzl * srcp;
    if (x == 0 && y == 0) return r;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    h = ((z + 512) >>> 10) + longint'(decl_model);
    h = h % 23040;
    if (h < 0) h += 23040;
    r.heading = h[14:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Offer one item, hold until accepted, log its expected result, and pause at random unless quiet
  task automatic send_item(input stim_row_t s);
    in_tvalid <= 1'b1;
    in_tdata <= {s.mz, s.my, s.mx, s.az, s.ay, s.ax};
    do @(posedge clk); while (!in_tready);
    heading_q.push_back(s.typed ? s.res : compute_heading(s.ax, s.ay, s.az, s.mx, s.my, s.mz));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Drain the pipeline, then load a new declination
  task automatic write_decl(input logic [14:0] v);
    in_tvalid <= 1'b0;
    wait (heading_q.size() == 0);
    repeat (80) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decl_model = v;
  endtask

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t s;
    int        k;
    k = $urandom_range(0, 19);
    s.typed = 1'b0;
    s.res = '0;
    s.ax = rnd16(); s.ay = rnd16(); s.az = rnd16();
    s.mx = rnd16(); s.my = rnd16(); s.mz = rnd16();
    // small tilt vectors, zero vectors and level poses now and then
    if (k == 0) begin
      s.ax = 0; s.ay = 0; s.az = 0;
    end else if (k == 1) begin
      s.mx = 0; s.my = 0; s.mz = 0;
    end else if (k < 5) begin
      s.ax = $signed(4'($urandom)); s.ay = $signed(4'($urandom));
      s.az = $signed(4'($urandom));
    end else if (k < 8) begin
      s.ax = 0; s.ay = 0;
    end
    return s;
  endfunction

  stim_row_t directed[$];
  logic [14:0] decl_list[6];

  // Receiver: random short stalls, one long hold on request, always ready when quiet
  initial begin
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected item heading=%0d valid=%0b", $time, out_tdata[14:0],
                 out_tuser[0]);
        fail_count++;
      end else begin
        heading_t e;
        e = heading_q.pop_front();
        if (out_tdata[14:0] !== e.heading) begin
          $display("%0t: heading expected %0d actual %0d", $time, e.heading, out_tdata[14:0]);
          fail_count++;
        end
        if (out_tuser[0] !== e.valid_res) begin
          $display("%0t: valid_res expected %0b actual %0b", $time, e.valid_res, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tilt_compensated_heading_unit test failed");
    $finish;
  end

  initial begin
    //                 ax      ay      az      mx      my      mz     typed  result
    directed.push_back('{0, 0, 0, 1000, 2000, 3000, 1'b1, '{15'd0, 1'b0}});
    directed.push_back('{0, 0, 0, -32768, 32767, -32768, 1'b1, '{15'd0, 1'b0}});
    directed.push_back('{100, -200, 300, 0, 0, 0, 1'b1, '{15'd0, 1'b0}});
    directed.push_back('{0, 0, 1000, 100, 0, 0, 1'b0, '0});
    directed.push_back('{0, 0, 1000, -100, 0, 0, 1'b0, '0});
    directed.push_back('{0, 0, 1000, 0, 100, 0, 1'b0, '0});
    directed.push_back('{0, 0, 1000, 0, -100, 0, 1'b0, '0});
    directed.push_back('{0, 0, 1000, -100, -1, 0, 1'b0, '0});
    directed.push_back('{-32768, -32768, -32768, 32767, 32767, 32767, 1'b0, '0});
    directed.push_back('{32767, 32767, 32767, -32768, -32768, -32768, 1'b0, '0});
    directed.push_back('{-32768, 0, 0, 32767, -32768, 32767, 1'b0, '0});
    directed.push_back('{0, 32767, 0, -32768, 32767, 32767, 1'b0, '0});
    directed.push_back('{1, 0, 0, 1, 1, 1, 1'b0, '0});
    directed.push_back('{0, -1, 0, -1, -1, -1, 1'b0, '0});
    directed.push_back('{-1, -1, -1, 1, -1, 1, 1'b0, '0});
    directed.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, 1'b0, '0});
    directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 1'b0, '0});

    decl_list = '{DECL_RESET, 15'd0, 15'd23039, 15'h7FFF, 15'd11520, 15'($urandom)};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_decl(decl_list[p]);
      if (p == 5) quiet = 1'b1;
      for (int n = 0; n < 220; n++) begin
        if (p == 2 && n == 20) hold_req = 1'b1;
        send_item(rand_row());
      end
    end
    in_tvalid <= 1'b0;

    wait (heading_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tilt_compensated_heading_unit test passed");
    end else begin
      $display("tilt_compensated_heading_unit test failed");
    end
    $finish;
  end

endmodule
